/* src/fnpc_pkg.sv */
// Shared constants and types for the four-neighbor peak clipper.
// Used by fnpc_stencil and four_neighbor_peak_clip; no dependencies.
package fnpc_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int PIX_W     = 16;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ROWS = CFG_IDX_W'(0),
    CFG_FRAME_COLS = CFG_IDX_W'(1)
  } cfg_idx_e;

  // Position of an accepted pixel plus its boundary flags.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             has_up;
    logic             has_up2;
    logic             has_left;
    logic             has_left2;
    logic             last_row;
    logic             last_col;
  } pos_t;

  // One line buffer entry: the two rows above the current one.
  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] up2;
  } line_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] value;
    logic             done;
  } result_t;

endpackage

/* src/fnpc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fnpc_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/fnpc_stencil.sv */
// Stencil stage: line buffer RAM read-modify-write, neighbor window and clipping.
// Depends on fnpc_pkg and fnpc_ram.
module fnpc_stencil (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_take_i,
  input  fnpc_pkg::pos_t              in_pos_i,
  input  logic [fnpc_pkg::PIX_W-1:0]  in_pixel_i,
  output logic                        in_ready_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output fnpc_pkg::result_t           res_o
);

  function automatic logic [fnpc_pkg::PIX_W-1:0] pmax(
    input logic [fnpc_pkg::PIX_W-1:0] a,
    input logic [fnpc_pkg::PIX_W-1:0] b
  );
    pmax = (a > b) ? a : b;
  endfunction

  // Stage holding the item being emitted
  logic                       s_valid_q, s_valid_d;
  fnpc_pkg::pos_t             s_pos_q;
  logic [fnpc_pkg::PIX_W-1:0] s_pix_q;
  logic [2:0]                 issued_q, issued_d;

  // Window: u_* row above, uu_0 two rows above, l_* current row to the left
  logic [fnpc_pkg::PIX_W-1:0] u_m1_q, u_0_q, uu_0_q, l_m1_q, l_m2_q;
  fnpc_pkg::line_t            first_q;   // column 0 entry of the current row
  logic                       fwd_q;
  fnpc_pkg::line_t            fwd_data_q;

  fnpc_pkg::line_t            ram_rdata, rd, wdata, shift_in;
  logic [fnpc_pkg::COL_W-1:0] raddr;
  logic                       s_done;

  logic [fnpc_pkg::PIX_W-1:0] u_p1, nmax_a, nmax_b, nmax_c;
  fnpc_pkg::result_t          res_a, res_b, res_c;
  logic [2:0]                 need, pend, sel, rest;

  assign raddr = in_pos_i.col + fnpc_pkg::COL_W'(1);
  assign wdata = '{up: s_pix_q, up2: u_0_q};
  assign rd    = fwd_q ? fwd_data_q : ram_rdata;
  assign u_p1  = rd.up;
  assign shift_in = s_pos_q.last_col ? (s_pos_q.has_left ? first_q : wdata) : rd;

  fnpc_ram #(
    .Width ($bits(fnpc_pkg::line_t)),
    .Depth (fnpc_pkg::MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s_done),
    .waddr_i (s_pos_q.col),
    .wdata_i (wdata),
    .re_i    (in_take_i),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Neighbor maxima; absent neighbors contribute 0
  always_comb begin
    nmax_a = pmax(pmax(s_pix_q, s_pos_q.has_up2 ? uu_0_q : '0),
                  pmax(s_pos_q.has_left ? u_m1_q : '0, s_pos_q.last_col ? '0 : u_p1));
    nmax_b = pmax(s_pix_q, pmax(s_pos_q.has_up ? u_m1_q : '0,
                                s_pos_q.has_left2 ? l_m2_q : '0));
    nmax_c = pmax(s_pos_q.has_up ? u_0_q : '0, s_pos_q.has_left ? l_m1_q : '0);

    res_a.row   = s_pos_q.row - fnpc_pkg::ROW_W'(1);
    res_a.col   = s_pos_q.col;
    res_a.value = (u_0_q > nmax_a) ? nmax_a : u_0_q;
    res_a.done  = 1'b0;

    res_b.row   = s_pos_q.row;
    res_b.col   = s_pos_q.col - fnpc_pkg::COL_W'(1);
    res_b.value = (l_m1_q > nmax_b) ? nmax_b : l_m1_q;
    res_b.done  = 1'b0;

    res_c.row   = s_pos_q.row;
    res_c.col   = s_pos_q.col;
    res_c.value = (s_pix_q > nmax_c) ? nmax_c : s_pix_q;
    res_c.done  = 1'b1;
  end

  // Up to three results per item, issued in order a, b, c
  always_comb begin
    need = {s_pos_q.last_row & s_pos_q.last_col,
            s_pos_q.last_row & s_pos_q.has_left,
            s_pos_q.has_up};
    pend = s_valid_q ? (need & ~issued_q) : 3'b000;
    sel  = {pend[2] & ~pend[1] & ~pend[0], pend[1] & ~pend[0], pend[0]};
    rest = pend & ~sel;
    s_done = s_valid_q && ((pend == 3'b000) || (res_ready_i && (rest == 3'b000)));

    if (sel[0]) begin
      res_o = res_a;
    end else if (sel[1]) begin
      res_o = res_b;
    end else begin
      res_o = res_c;
    end

    if (s_done) begin
      issued_d = 3'b000;
    end else if (res_ready_i) begin
      issued_d = issued_q | sel;
    end else begin
      issued_d = issued_q;
    end

    if (in_take_i) begin
      s_valid_d = 1'b1;
    end else if (s_done) begin
      s_valid_d = 1'b0;
    end else begin
      s_valid_d = s_valid_q;
    end
  end

  assign res_valid_o = (pend != 3'b000);
  assign in_ready_o  = !s_valid_q || s_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      issued_q  <= 3'b000;
      fwd_q     <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
      issued_q  <= issued_d;
      if (in_take_i) begin
        // entry being written this cycle is the one read: bypass the RAM
        fwd_q <= s_done && (s_pos_q.col == raddr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      s_pos_q    <= in_pos_i;
      s_pix_q    <= in_pixel_i;
      fwd_data_q <= wdata;
    end
    if (s_done) begin
      u_m1_q <= u_0_q;
      u_0_q  <= shift_in.up;
      uu_0_q <= shift_in.up2;
      l_m2_q <= l_m1_q;
      l_m1_q <= s_pix_q;
      if (!s_pos_q.has_left) begin
        first_q <= wdata;
      end
    end
  end

endmodule

/* src/four_neighbor_peak_clip.sv */
// Top level of the four-neighbor peak clipper: frame registers, raster position, output register.
// Depends on fnpc_pkg and fnpc_stencil.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / pixel_value_i): one pixel per transaction, raster
//    order, row by row. The block tracks the position itself.
//  - Output channel (out_valid_o / out_stall_i): one cell per transaction with its row, column,
//    clipped value and frame_done on the frame's last cell. Every cell comes out exactly once.
//  - Config channel (cfg_valid_i / cfg_ready_o): index 0 = frame_rows, 1 = frame_cols. Always
//    ready. A write to either register restarts the frame at row 0, column 0. A count of 0
//    acts as 1, a count above the maximum acts as the maximum. Write only while idle.
//  - Ordering: a pixel is registered in the stencil stage and its results then pass through the
//    output register. Cell (r-1,c) is emitted when pixel (r,c) arrives; on the last row the
//    pixel also releases cell (r,c-1), and the frame's last pixel releases itself.
//  - Throughput: one pixel per cycle on all rows but the last, while the output is not stalled.
//    Row 0 pixels of a multi-row frame release nothing. A pixel with several results (up to 3)
//    holds the stencil stage while the single output register drains them one result a cycle.
//  - Line buffer: one RAM entry per column holding the two rows above; read one column ahead at
//    acceptance, written back when the pixel retires, with a bypass for narrow frames.
//  - Reset: position 0,0, both sizes 1, pipeline empty. RAM contents need no clearing: every
//    read used is of data written earlier in the same frame.
//  - Output stall: the result holds in the output register; the stencil stage waits and the
//    input stalls once that stage cannot retire its pixel.
module four_neighbor_peak_clip (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fnpc_pkg::PIX_W-1:0]      pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fnpc_pkg::ROW_W-1:0]      out_row_o,
  output logic [fnpc_pkg::COL_W-1:0]      out_col_o,
  output logic [fnpc_pkg::PIX_W-1:0]      out_value_o,
  output logic                            frame_done_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fnpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fnpc_pkg::CNT_W-1:0]      cfg_data_i
);

  logic [fnpc_pkg::CNT_W-1:0] frame_rows_q, frame_rows_d;
  logic [fnpc_pkg::CNT_W-1:0] frame_cols_q, frame_cols_d;
  logic [fnpc_pkg::ROW_W-1:0] row_q, row_d;
  logic [fnpc_pkg::COL_W-1:0] col_q, col_d;
  logic [fnpc_pkg::CNT_W-1:0] rows_eff, cols_eff;
  logic [fnpc_pkg::ROW_W-1:0] cur_row;
  logic [fnpc_pkg::COL_W-1:0] cur_col;
  logic                       wrap, cfg_hit, in_take, st_ready;
  fnpc_pkg::pos_t             pos;

  logic                       res_valid, res_ready;
  fnpc_pkg::result_t          res;
  logic                       out_valid_q, out_valid_d;
  fnpc_pkg::result_t          out_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !st_ready;
  assign in_take     = in_valid_i && st_ready;

  // Clamp the frame sizes to 1..max
  always_comb begin
    if (frame_rows_q == '0) begin
      rows_eff = fnpc_pkg::CNT_W'(1);
    end else if (frame_rows_q > fnpc_pkg::CNT_W'(fnpc_pkg::MAX_ROWS)) begin
      rows_eff = fnpc_pkg::CNT_W'(fnpc_pkg::MAX_ROWS);
    end else begin
      rows_eff = frame_rows_q;
    end
    if (frame_cols_q == '0) begin
      cols_eff = fnpc_pkg::CNT_W'(1);
    end else if (frame_cols_q > fnpc_pkg::CNT_W'(fnpc_pkg::MAX_COLS)) begin
      cols_eff = fnpc_pkg::CNT_W'(fnpc_pkg::MAX_COLS);
    end else begin
      cols_eff = frame_cols_q;
    end
  end

  // Position of the arriving pixel and its boundary flags
  always_comb begin
    wrap    = (fnpc_pkg::CNT_W'(row_q) >= rows_eff) || (fnpc_pkg::CNT_W'(col_q) >= cols_eff);
    cur_row = wrap ? '0 : row_q;
    cur_col = wrap ? '0 : col_q;

    pos.row       = cur_row;
    pos.col       = cur_col;
    pos.has_up    = (cur_row != '0);
    pos.has_up2   = (cur_row > fnpc_pkg::ROW_W'(1));
    pos.has_left  = (cur_col != '0);
    pos.has_left2 = (cur_col > fnpc_pkg::COL_W'(1));
    pos.last_row  = (fnpc_pkg::CNT_W'(cur_row) + fnpc_pkg::CNT_W'(1) == rows_eff);
    pos.last_col  = (fnpc_pkg::CNT_W'(cur_col) + fnpc_pkg::CNT_W'(1) == cols_eff);
  end

  // Config writes restart the frame and take priority over the position update
  always_comb begin
    frame_rows_d = frame_rows_q;
    frame_cols_d = frame_cols_q;
    cfg_hit      = 1'b0;
    row_d        = row_q;
    col_d        = col_q;

    if (in_take) begin
      if (pos.last_col) begin
        col_d = '0;
        row_d = pos.last_row ? '0 : cur_row + fnpc_pkg::ROW_W'(1);
      end else begin
        col_d = cur_col + fnpc_pkg::COL_W'(1);
        row_d = cur_row;
      end
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        fnpc_pkg::CFG_FRAME_ROWS: begin
          frame_rows_d = cfg_data_i;
          cfg_hit      = 1'b1;
        end
        fnpc_pkg::CFG_FRAME_COLS: begin
          frame_cols_d = cfg_data_i;
          cfg_hit      = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end

    if (cfg_hit) begin
      row_d = '0;
      col_d = '0;
    end
  end

  fnpc_stencil u_stencil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_take_i   (in_take),
    .in_pos_i    (pos),
    .in_pixel_i  (pixel_value_i),
    .in_ready_o  (st_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads whenever it is empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q <= fnpc_pkg::CNT_W'(1);
      frame_cols_q <= fnpc_pkg::CNT_W'(1);
      row_q        <= '0;
      col_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      frame_rows_q <= frame_rows_d;
      frame_cols_q <= frame_cols_d;
      row_q        <= row_d;
      col_q        <= col_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_q.row;
  assign out_col_o    = out_q.col;
  assign out_value_o  = out_q.value;
  assign frame_done_o = out_q.done;

`ifndef SYNTHESIS
  // Input only stalls while the stencil stage still has results to hand out
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> res_valid)
    else $error("input stalled with no pending result");

  // A result blocked at the output register must hold off new pixels
  a_blocked_result_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |-> in_stall_o)
    else $error("pixel accepted while a result is blocked");

  // Raster position stays inside the configured frame
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fnpc_pkg::CNT_W'(row_q) < rows_eff) && (fnpc_pkg::CNT_W'(col_q) < cols_eff))
    else $error("raster position outside frame");
`endif

endmodule
